### hw/rtl/epwr_pkg.sv
`default_nettype none
package epwr_pkg;

	localparam int COUNTER_WIDTH_DEF = 32;
	localparam int OVERFLOW_BITS_DEF = 6;
	localparam int OVERFLOW_BITS_MAX = 8;
	localparam int CAPTURE_W = 32;
	localparam int WEIGHT_W = 32;
	localparam int PULSE_W = 38;
	localparam int DIST_W = 16;

	localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = {WEIGHT_W{1'b1}};

	// distance = pulse * 34000 / 2000000 = pulse * 17 / 1000
	// pulse at or above this gives a distance past 16 bits
	localparam logic [PULSE_W-1:0] DIST_SAT_PULSE = PULSE_W'(3855059);
	localparam int LIN_W = 22;
	localparam int SCALED_W = LIN_W + 5;
	localparam int QUOT_W = SCALED_W - 3;
	// floor(y / 125) = (y * RECIP_M) >> RECIP_SHIFT for y below 2^23
	localparam int RECIP_W = 24;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(8589935);
	localparam int RECIP_SHIFT = 30;

	localparam int QUEUE_DEPTH = 2;

	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam int PADDR_W = 3;
	localparam logic REG_OVERFLOW_WEIGHT = 1'b0;

	typedef struct packed {
		logic op;
		logic overflow_flag;
		logic capture_flag;
		logic [CAPTURE_W-1:0] capture_value;
	} in_beat_t;

	typedef struct packed {
		logic done_res;
		logic [PULSE_W-1:0] pulse_us;
		logic [DIST_W-1:0] distance_cm;
		logic clear_counter;
		logic falling_edge_select;
	} out_beat_t;

	typedef struct packed {
		logic done;
		logic [OVERFLOW_BITS_MAX-1:0] count;
		logic [CAPTURE_W-1:0] held;
		logic clear_counter;
		logic falling_edge_select;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		logic full;
		logic valid;
	} queue_sts_t;

endpackage
`default_nettype wire

### hw/rtl/epwr_front.sv
`default_nettype none
module epwr_front #(
	parameter int COUNTER_WIDTH = epwr_pkg::COUNTER_WIDTH_DEF,
	parameter int OVERFLOW_BITS = epwr_pkg::OVERFLOW_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire epwr_pkg::in_beat_t beat,
	output epwr_pkg::job_t         job
);

	localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = {OVERFLOW_BITS{1'b1}};
	localparam logic [COUNTER_WIDTH-1:0] CNT_ONES = {COUNTER_WIDTH{1'b1}};

	logic done_q, armed_q;
	logic [OVERFLOW_BITS-1:0] count_q;
	logic [COUNTER_WIDTH-1:0] held_q;

	logic done_d, armed_d, clr_d;
	logic [OVERFLOW_BITS-1:0] count_d;
	logic [COUNTER_WIDTH-1:0] held_d;

	always_comb begin
		done_d = done_q;
		armed_d = armed_q;
		count_d = count_q;
		held_d = held_q;
		clr_d = 1'b0;
		if (beat.op == epwr_pkg::OP_RESTART) begin
			done_d = 1'b0;
			armed_d = 1'b0;
			count_d = '0;
		end else if (!done_q) begin
			// overflow is counted first when both flags are set; a capture then overrides held
			if (beat.overflow_flag && armed_q) begin
				if (count_q == OVF_MAX) begin
					done_d = 1'b1;
					held_d = CNT_ONES;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			if (beat.capture_flag) begin
				if (armed_q) begin
					done_d = 1'b1;
					held_d = beat.capture_value[COUNTER_WIDTH-1:0];
				end else begin
					count_d = '0;
					held_d = '0;
					armed_d = 1'b1;
					clr_d = 1'b1;
				end
			end
		end
	end

	always_comb begin
		job.done = done_d;
		job.count = epwr_pkg::OVERFLOW_BITS_MAX'(count_d);
		job.held = epwr_pkg::CAPTURE_W'(held_d);
		job.clear_counter = clr_d;
		job.falling_edge_select = armed_d && !done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			armed_q <= 1'b0;
			count_q <= '0;
			held_q <= '0;
		end else if (accept) begin
			done_q <= done_d;
			armed_q <= armed_d;
			count_q <= count_d;
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/epwr_queue.sv
`default_nettype none
module epwr_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire epwr_pkg::queue_ctl_t ctl,
	input  wire epwr_pkg::job_t      wr_job,
	output epwr_pkg::queue_sts_t     sts,
	output epwr_pkg::job_t           rd_job
);

	localparam int DEPTH = epwr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	epwr_pkg::job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	logic do_push, do_pop;

	assign sts.full = (fill_q == CNT_W'(DEPTH));
	assign sts.valid = (fill_q != '0);
	assign do_push = ctl.push && !sts.full;
	assign do_pop = ctl.pop && sts.valid;
	assign rd_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/epwr_back.sv
`default_nettype none
module epwr_back #(
	parameter int COUNTER_WIDTH = epwr_pkg::COUNTER_WIDTH_DEF,
	parameter int OVERFLOW_BITS = epwr_pkg::OVERFLOW_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [epwr_pkg::WEIGHT_W-1:0]   weight,
	input  wire logic                            job_valid,
	input  wire epwr_pkg::job_t                  job,
	output logic                                 job_pop,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output epwr_pkg::out_beat_t                  out_data
);

	localparam int PROD_W = OVERFLOW_BITS + epwr_pkg::WEIGHT_W;
	localparam int EXT_W = (PROD_W + 1 > epwr_pkg::PULSE_W) ? PROD_W + 1 : epwr_pkg::PULSE_W;
	localparam int RPROD_W = epwr_pkg::QUOT_W + epwr_pkg::RECIP_W;

	typedef struct packed {
		logic done;
		logic clr;
		logic fall;
	} tag_t;

	logic advance;
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic [PROD_W-1:0] prod_s1;
	logic [COUNTER_WIDTH-1:0] held_s1;
	logic [epwr_pkg::PULSE_W-1:0] pulse_s2, pulse_s3, pulse_s4;
	logic sat_s3, sat_s4;
	logic [epwr_pkg::QUOT_W-1:0] y_s3;
	logic [RPROD_W-1:0] rprod_s4;
	epwr_pkg::out_beat_t out_data_q;

	logic [EXT_W-1:0] sum_ext;
	logic [epwr_pkg::SCALED_W-1:0] scaled;

	assign advance = !(out_valid_q && out_stall);
	assign job_pop = advance && job_valid;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign sum_ext = EXT_W'(prod_s1) + EXT_W'(held_s1);
	// times 17 as shift and add
	assign scaled = epwr_pkg::SCALED_W'({pulse_s2[epwr_pkg::LIN_W-1:0], 4'b0000})
		+ epwr_pkg::SCALED_W'(pulse_s2[epwr_pkg::LIN_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tag_s1 <= '{done: job.done, clr: job.clear_counter, fall: job.falling_edge_select};
			prod_s1 <= PROD_W'(job.count[OVERFLOW_BITS-1:0]) * PROD_W'(weight);
			held_s1 <= job.held[COUNTER_WIDTH-1:0];

			tag_s2 <= tag_s1;
			pulse_s2 <= (sum_ext > EXT_W'(epwr_pkg::PULSE_MAX)) ? epwr_pkg::PULSE_MAX
				: sum_ext[epwr_pkg::PULSE_W-1:0];

			tag_s3 <= tag_s2;
			pulse_s3 <= pulse_s2;
			sat_s3 <= (pulse_s2 >= epwr_pkg::DIST_SAT_PULSE);
			y_s3 <= scaled[epwr_pkg::SCALED_W-1:3];

			tag_s4 <= tag_s3;
			pulse_s4 <= pulse_s3;
			sat_s4 <= sat_s3;
			rprod_s4 <= RPROD_W'(y_s3) * RPROD_W'(epwr_pkg::RECIP_M);

			out_data_q.done_res <= tag_s4.done;
			out_data_q.pulse_us <= tag_s4.done ? pulse_s4 : '0;
			out_data_q.distance_cm <= !tag_s4.done ? '0
				: sat_s4 ? epwr_pkg::DIST_MAX
				: rprod_s4[epwr_pkg::RECIP_SHIFT +: epwr_pkg::DIST_W];
			out_data_q.clear_counter <= tag_s4.clr;
			out_data_q.falling_edge_select <= tag_s4.fall;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/echo_pulse_width_ranger_unit.sv
// channel | direction | handshake           | beat
// in      | input     | in_valid / in_stall | in_data (epwr_pkg::in_beat_t)
// out     | output    | out_valid/out_stall | out_data (epwr_pkg::out_beat_t)
// cfg     | input     | apb write/read      | overflow_weight at byte address 0
//
// the front updates the measurement state in the accept cycle and queues one job per beat
// the back is a five-register pipeline (multiply, add and saturate, scale, reciprocal
// multiply, output) that takes one beat per cycle while out_stall does not hold it
// in_stall rises only when the two-entry job queue is full; out_stall freezes the back
// reset clears the measurement state, the queue and all valid flags; weight resets to all ones
`default_nettype none
module echo_pulse_width_ranger_unit #(
	parameter int COUNTER_WIDTH = epwr_pkg::COUNTER_WIDTH_DEF,
	parameter int OVERFLOW_BITS = epwr_pkg::OVERFLOW_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire epwr_pkg::in_beat_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output epwr_pkg::out_beat_t                out_data,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [epwr_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	logic [epwr_pkg::WEIGHT_W-1:0] weight_q;
	logic reg_hit, in_accept;
	epwr_pkg::job_t front_job, queue_job;
	epwr_pkg::queue_ctl_t q_ctl;
	epwr_pkg::queue_sts_t q_sts;
	logic back_pop;

	assign pready = 1'b1;
	assign reg_hit = (paddr[epwr_pkg::PADDR_W-1:2] == epwr_pkg::REG_OVERFLOW_WEIGHT);
	assign prdata = reg_hit ? weight_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= epwr_pkg::WEIGHT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			weight_q <= pwdata;
		end
	end

	assign in_stall = q_sts.full;
	assign in_accept = in_valid && !in_stall;
	assign q_ctl.push = in_accept;
	assign q_ctl.pop = back_pop;

	epwr_front #(
		.COUNTER_WIDTH(COUNTER_WIDTH),
		.OVERFLOW_BITS(OVERFLOW_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_accept),
		.beat(in_data),
		.job(front_job)
	);

	epwr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(q_ctl),
		.wr_job(front_job),
		.sts(q_sts),
		.rd_job(queue_job)
	);

	epwr_back #(
		.COUNTER_WIDTH(COUNTER_WIDTH),
		.OVERFLOW_BITS(OVERFLOW_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.weight(weight_q),
		.job_valid(q_sts.valid),
		.job(queue_job),
		.job_pop(back_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.done_res |-> out_data.pulse_us == '0 && out_data.distance_cm == '0)
		else $error("result fields set without a finished measurement");

	a_arm_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clear_counter |-> out_data.falling_edge_select && !out_data.done_res)
		else $error("arming beat without falling-edge polarity");

	a_dist_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res && out_data.pulse_us >= epwr_pkg::DIST_SAT_PULSE
		|-> out_data.distance_cm == epwr_pkg::DIST_MAX)
		else $error("distance not saturated for a long pulse");

	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		back_pop |-> q_sts.valid)
		else $error("job taken from an empty queue");

endmodule
`default_nettype wire
